[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
// Used by bba_ctrl, bba_datapath and bitmap_block_allocator; no dependencies.
package bba_pkg;

    // Bitmap geometry: one occupancy word covers 64 blocks
    localparam int WORD_BITS        = 64;
    localparam int BIT_W            = 6;
    localparam int DEF_MAX_BLOCKS   = 1024;
    localparam int RESET_BLOCKS     = 1024;

    // Operation codes carried on func
    typedef enum logic [1:0] {
        FUNC_ALLOC     = 2'd0,
        FUNC_FREE      = 2'd1,
        FUNC_QUERY     = 2'd2,
        FUNC_SET_FLAGS = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_NOT_ALLOC = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_TEST,
        S_ACC_RD,
        S_ACC_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic scan_read;
        logic scan_step;
        logic acc_read;
        logic alloc_commit;
        logic full_commit;
        logic acc_commit;
        logic cfg_load;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic word_has_clear;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/bba_ctrl.sv]
// Sequencing state machine for the bitmap block allocator.
// Depends on bba_pkg; drives the command struct consumed by bba_datapath.
module bba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           func,
    input  logic                 cfg_valid,
    input  bba_pkg::dp_stat_t    stat,
    output logic                 req_stall,
    output logic                 cfg_ready,
    output bba_pkg::ctrl_cmd_t   cmd
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.cfg_load = cfg_valid;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (func_t'(func) == FUNC_ALLOC) ? S_ALLOC_RD : S_ACC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_ALLOC_TEST;
            end
            S_ALLOC_TEST:
            begin
                if (stat.word_has_clear)
                begin
                    if (stat.out_free)
                    begin
                        cmd.alloc_commit = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (stat.scan_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.full_commit = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_ALLOC_RD;
                end
            end
            S_ACC_RD:
            begin
                cmd.acc_read = 1'b1;
                state_next   = S_ACC_EXEC;
            end
            S_ACC_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.acc_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Both ports open only between operations
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // An accepted beat always starts a scan or an access
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_ALLOC_RD || state_reg == S_ACC_RD))
        else $error("accepted request did not start an operation");

    // Results are only written into a free output slot
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit || cmd.full_commit || cmd.acc_commit) |-> stat.out_free)
        else $error("result committed over a stalled result");

    // Scan moves on only past a full word that is not the last one
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (!stat.word_has_clear && !stat.scan_last))
        else $error("scan stepped past a usable word");

endmodule

[rtl/bba_datapath.sv]
// Datapath of the bitmap block allocator: bitmap, tag and flag memories,
// counters and result register. Depends on bba_pkg; steered by bba_ctrl.
module bba_datapath #(
    parameter  int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    localparam int IDX_W      = $clog2(MAX_BLOCKS),
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bba_pkg::ctrl_cmd_t   cmd,
    output bba_pkg::dp_stat_t    stat,
    input  logic [1:0]           func,
    input  logic [IDX_W-1:0]     block_index,
    input  logic [31:0]          tag,
    input  logic [7:0]           new_flags,
    input  logic [CNT_W-1:0]     block_count,
    input  logic                 rsp_stall,
    output logic                 rsp_valid,
    output logic [1:0]           status,
    output logic [IDX_W-1:0]     granted_index,
    output logic [31:0]          stored_tag,
    output logic [7:0]           stored_flags,
    output logic [CNT_W-1:0]     free_blocks,
    output logic                 all_free
);
    import bba_pkg::*;

    localparam int DEPTH     = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_COUNT = (RESET_BLOCKS < MAX_BLOCKS) ? RESET_BLOCKS : MAX_BLOCKS;

    // Occupancy word for a freshly set up slab: bits at or past cnt are set
    function automatic logic [WORD_BITS-1:0] init_word(input logic [WADDR_W-1:0] w,
                                                       input logic [CNT_W-1:0]   cnt);
        logic [CNT_W-1:0] full_words;
        logic [WORD_BITS-1:0] ones;
        full_words = cnt >> BIT_W;
        ones       = '1;
        if (CNT_W'(w) < full_words)
            return '0;
        else if (CNT_W'(w) == full_words)
            return ones << cnt[BIT_W-1:0];
        else
            return ones;
    endfunction

    // Captured request
    func_t              func_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [31:0]        tag_reg;
    logic [7:0]         flags_reg;

    // Slab state
    logic [WORD_BITS-1:0] map_reg [DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     free_reg;
    logic [WADDR_W-1:0]   hint_reg;

    // Scan state
    logic [WADDR_W-1:0]   ptr_reg;
    logic [WADDR_W-1:0]   scan_cnt_reg;
    logic [WORD_BITS-1:0] word_reg;

    // Block memories
    logic [31:0] tag_mem  [MAX_BLOCKS];
    logic [7:0]  flag_mem [MAX_BLOCKS];
    logic [31:0] rd_tag_reg;
    logic [7:0]  rd_flags_reg;

    // Result register
    logic               rsp_valid_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   granted_reg;
    logic [31:0]        stored_tag_reg;
    logic [7:0]         stored_flags_reg;
    logic [CNT_W-1:0]   free_blocks_reg;
    logic               all_free_reg;

    // Combinational helpers
    logic [CNT_W-1:0]   cfg_clamped;
    logic [WADDR_W-1:0] idx_word;
    logic [WADDR_W-1:0] map_raddr;
    logic [WADDR_W-1:0] ptr_wrap;
    logic [BIT_W-1:0]   gbit;
    logic [IDX_W-1:0]   grant_idx;
    logic               in_range;
    logic               acc_bit;
    logic               acc_ok;
    status_t            acc_status;
    logic               do_free;
    logic               do_read;
    logic               flag_we;
    logic [7:0]         flag_wdata;
    logic [IDX_W-1:0]   mem_waddr;

    // Register write value, forced into 1..MAX_BLOCKS
    always_comb
    begin
        if (block_count == '0)
            cfg_clamped = CNT_W'(1);
        else if (block_count > CNT_W'(MAX_BLOCKS))
            cfg_clamped = CNT_W'(MAX_BLOCKS);
        else
            cfg_clamped = block_count;
    end

    // Word addressing
    assign idx_word  = WADDR_W'(idx_reg >> BIT_W);
    assign map_raddr = cmd.acc_read ? idx_word : ptr_reg;
    assign ptr_wrap  = (ptr_reg == WADDR_W'(DEPTH - 1)) ? '0 : ptr_reg + WADDR_W'(1);

    // Lowest clear bit of the scanned word
    always_comb
    begin
        gbit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word_reg[i])
                gbit = BIT_W'(i);
        end
    end

    assign grant_idx = IDX_W'({ptr_reg, gbit});

    // Checks for free, query and set flags
    always_comb
    begin
        in_range = CNT_W'(idx_reg) < count_reg;
        acc_bit  = word_reg[idx_reg[BIT_W-1:0]];
        acc_ok   = in_range && acc_bit;
        if (!in_range)
            acc_status = STAT_RANGE;
        else if (!acc_bit)
            acc_status = STAT_NOT_ALLOC;
        else
            acc_status = STAT_OK;
    end

    assign do_free = cmd.acc_commit && acc_ok && (func_reg == FUNC_FREE);
    assign do_read = acc_ok && (func_reg == FUNC_FREE || func_reg == FUNC_QUERY);

    // Memory write port: allocate writes tag and clears flags, set flags writes flags
    assign flag_we    = cmd.alloc_commit ||
                        (cmd.acc_commit && acc_ok && func_reg == FUNC_SET_FLAGS);
    assign flag_wdata = cmd.alloc_commit ? 8'h00 : flags_reg;
    assign mem_waddr  = cmd.alloc_commit ? grant_idx : idx_reg;

    // Request capture and scan word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func_t'(func);
            idx_reg   <= block_index;
            tag_reg   <= tag;
            flags_reg <= new_flags;
        end
        if (cmd.scan_read || cmd.acc_read)
        begin
            word_reg <= map_reg[map_raddr];
        end
    end

    // Tag and flag memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_commit)
        begin
            tag_mem[mem_waddr] <= tag_reg;
        end
        if (flag_we)
        begin
            flag_mem[mem_waddr] <= flag_wdata;
        end
        if (cmd.acc_read)
        begin
            rd_tag_reg   <= tag_mem[idx_reg];
            rd_flags_reg <= flag_mem[idx_reg];
        end
    end

    // Slab state and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < DEPTH; w++)
            begin
                map_reg[w] <= init_word(WADDR_W'(w), CNT_W'(RST_COUNT));
            end
            count_reg    <= CNT_W'(RST_COUNT);
            free_reg     <= CNT_W'(RST_COUNT);
            hint_reg     <= '0;
            ptr_reg      <= '0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_load)
            begin
                for (int w = 0; w < DEPTH; w++)
                begin
                    map_reg[w] <= init_word(WADDR_W'(w), cfg_clamped);
                end
                count_reg <= cfg_clamped;
                free_reg  <= cfg_clamped;
                hint_reg  <= '0;
            end
            else if (cmd.alloc_commit)
            begin
                map_reg[ptr_reg][gbit] <= 1'b1;
                free_reg               <= free_reg - CNT_W'(1);
                hint_reg               <= ptr_reg;
            end
            else if (do_free)
            begin
                map_reg[idx_word][idx_reg[BIT_W-1:0]] <= 1'b0;
                free_reg                              <= free_reg + CNT_W'(1);
                hint_reg                              <= idx_word;
            end

            // scan starts at the hint word
            if (cmd.load_in)
            begin
                ptr_reg      <= hint_reg;
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                ptr_reg      <= ptr_wrap;
                scan_cnt_reg <= scan_cnt_reg + WADDR_W'(1);
            end
        end
    end

    // Result valid: set on commit, cleared when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.alloc_commit || cmd.full_commit || cmd.acc_commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_commit)
        begin
            status_reg       <= STAT_OK;
            granted_reg      <= grant_idx;
            stored_tag_reg   <= '0;
            stored_flags_reg <= '0;
            free_blocks_reg  <= free_reg - CNT_W'(1);
            all_free_reg     <= 1'b0;
        end
        else if (cmd.full_commit)
        begin
            status_reg       <= STAT_FULL;
            granted_reg      <= '0;
            stored_tag_reg   <= '0;
            stored_flags_reg <= '0;
            free_blocks_reg  <= free_reg;
            all_free_reg     <= 1'b0;
        end
        else if (cmd.acc_commit)
        begin
            status_reg       <= acc_status;
            granted_reg      <= idx_reg;
            stored_tag_reg   <= do_read ? rd_tag_reg : '0;
            stored_flags_reg <= do_read ? rd_flags_reg : '0;
            free_blocks_reg  <= do_free ? free_reg + CNT_W'(1) : free_reg;
            all_free_reg     <= do_free && ((free_reg + CNT_W'(1)) == count_reg);
        end
    end

    // Status toward the controller
    assign stat.word_has_clear = ~&word_reg;
    assign stat.scan_last      = (scan_cnt_reg == WADDR_W'(DEPTH - 1));
    assign stat.out_free       = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign stored_tag    = stored_tag_reg;
    assign stored_flags  = stored_flags_reg;
    assign free_blocks   = free_blocks_reg;
    assign all_free      = all_free_reg;

    // Free count never passes the usable block count
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= count_reg)
        else $error("free count above block count");

    // Allocation never grants a block past the usable range
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> (CNT_W'(grant_idx) < count_reg))
        else $error("granted block outside the slab");

    // A successful free always has an allocated block to give back
    a_free_has_used: assert property (@(posedge clk) disable iff (!rst_n)
        do_free |-> (free_reg < count_reg))
        else $error("free with no block allocated");

endmodule

[rtl/bitmap_block_allocator.sv]
// Bitmap block allocator: one slab of equal blocks with occupancy bitmap,
// per-block tag and flag byte. Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Usage:
//   Request channel (req_valid / req_stall) carries func, block_index, tag and
//   new_flags; a beat is taken when req_valid is high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) returns exactly one result beat
//   per request: status, granted_index, stored_tag, stored_flags,
//   free_blocks and all_free.
//   Configuration channel (cfg_valid / cfg_ready, data on block_count) sets the
//   usable block count and rebuilds the bitmap; write it only between requests.
// Sequencing:
//   Free, query and set flags: accept, memory read, update; the result is
//   registered in the update step, and the next request is taken only once the
//   block is back in idle after that step.
//   Allocate: accept, then a read and a test of each bitmap word from the hint
//   word on, moving past full words until one has a clear bit or the last word
//   is tested; a full slab skips ceil(MAX_BLOCKS/64) - 1 words.
//   A stalled result is held in the output register; the next request is still
//   accepted and waits in its final step until the slot frees.
// Reset: bitmap cleared with bits past the count set, free count equal to the
//   block count (1024, or MAX_BLOCKS if smaller), hint at word 0.
module bitmap_block_allocator #(
    parameter  int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    localparam int IDX_W      = $clog2(MAX_BLOCKS),
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         func,
    input  logic [IDX_W-1:0]   block_index,
    input  logic [31:0]        tag,
    input  logic [7:0]         new_flags,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   granted_index,
    output logic [31:0]        stored_tag,
    output logic [7:0]         stored_flags,
    output logic [CNT_W-1:0]   free_blocks,
    output logic               all_free,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CNT_W-1:0]   block_count
);
    import bba_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (func),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .req_stall (req_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .block_index   (block_index),
        .tag           (tag),
        .new_flags     (new_flags),
        .block_count   (block_count),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .status        (status),
        .granted_index (granted_index),
        .stored_tag    (stored_tag),
        .stored_flags  (stored_flags),
        .free_blocks   (free_blocks),
        .all_free      (all_free)
    );

endmodule

[verif/bitmap_block_allocator_test.sv]
// Self-checking testbench for bitmap_block_allocator: random and directed requests
// against a local slab predictor, with random gaps on requests and random result stalls.
// Depends on rtl/bba_pkg.sv and the allocator RTL.
`timescale 1ns / 1ps

module bitmap_block_allocator_test;

    import bba_pkg::*;

    localparam int SLOTS       = DEF_MAX_BLOCKS;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAP_WORDS   = SLOTS / WORD_BITS;
    localparam int PLAN        = 0;     // slab copy used while generating stimulus
    localparam int TRACK       = 1;     // slab copy used to check the block
    localparam int GAP_PCT     = 29;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 10;
    localparam int NUM_PHASES  = 12;
    localparam longint TIMEOUT_NS = 64'd600_000 * 12;

    typedef struct {
        func_t              op;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        tg;
        logic [7:0]         fl;
    } req_t;

    typedef struct {
        func_t              op;
        status_t            st;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        tg;
        logic [7:0]         fl;
        logic [CNT_W-1:0]   nfree;
        logic               allf;
    } reply_t;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Block ports
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         func = FUNC_ALLOC;
    logic [IDX_W-1:0]   block_index = '0;
    logic [31:0]        tag = '0;
    logic [7:0]         new_flags = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [1:0]         status;
    logic [IDX_W-1:0]   granted_index;
    logic [31:0]        stored_tag;
    logic [7:0]         stored_flags;
    logic [CNT_W-1:0]   free_blocks;
    logic               all_free;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   block_count = CNT_W'(RESET_BLOCKS);

    bitmap_block_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .block_index    (block_index),
        .tag            (tag),
        .new_flags      (new_flags),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .granted_index  (granted_index),
        .stored_tag     (stored_tag),
        .stored_flags   (stored_flags),
        .free_blocks    (free_blocks),
        .all_free       (all_free),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .block_count    (block_count)
    );

    // Slab predictor state, two copies
    logic [63:0]    occ_map  [2][MAP_WORDS];
    logic [31:0]    tag_mem  [2][SLOTS];
    logic [7:0]     flag_mem [2][SLOTS];
    int unsigned    free_cnt [2];
    int unsigned    hint_w   [2];
    int unsigned    blk_cnt  [2];

    req_t           request_backlog [$];
    reply_t         due_replies [$];
    req_t           cur_req;

    int unsigned    send_gap_pct = GAP_PCT;
    int unsigned    recv_gap_pct = GAP_PCT;
    bit             hold_req = 1'b0;
    bit             hold_taken = 1'b0;
    int unsigned    hold_left = 0;

    int unsigned    error_count = 0;
    int unsigned    cfg_writes = 0;
    int unsigned    beats_seen = 0;
    int unsigned    op_seen [4];
    int unsigned    st_seen [4];
    int unsigned    empty_seen = 0;

    // Clamp the count and rebuild the bitmap; tags and flags survive
    function automatic void slab_configure(int s, logic [CNT_W-1:0] v);
        int unsigned cnt;
        int unsigned words;
        int unsigned i;
        cnt = 32'(v);
        if (cnt == 0)
            cnt = 1;
        if (cnt > SLOTS)
            cnt = SLOTS;
        blk_cnt[s] = cnt;
        words = (cnt + WORD_BITS - 1) / WORD_BITS;
        for (i = 0; i < MAP_WORDS; i++)
            occ_map[s][i] = '0;
        for (i = cnt; i < words * WORD_BITS; i++)
            occ_map[s][i / WORD_BITS][i % WORD_BITS] = 1'b1;
        free_cnt[s] = cnt;
        hint_w[s] = 0;
    endfunction

    // One request through the slab: updates state, returns the answer
    function automatic reply_t slab_step(int s, req_t r);
        reply_t         o;
        int unsigned    words;
        int unsigned    w;
        int unsigned    k;
        int unsigned    b;
        logic [63:0]    clr;
        bit             found;
        o.op = r.op;
        o.st = STAT_OK;
        o.idx = r.idx;
        o.tg = '0;
        o.fl = '0;
        o.allf = 1'b0;
        if (r.op == FUNC_ALLOC)
        begin
            words = (blk_cnt[s] + WORD_BITS - 1) / WORD_BITS;
            w = (hint_w[s] < words) ? hint_w[s] : 0;
            found = 1'b0;
            for (k = 0; k < words && !found; k++)
            begin
                clr = ~occ_map[s][w];
                if (clr != '0)
                begin
                    b = 0;
                    while (!clr[b])
                        b++;
                    occ_map[s][w][b] = 1'b1;
                    tag_mem[s][w * WORD_BITS + b] = r.tg;
                    flag_mem[s][w * WORD_BITS + b] = '0;
                    free_cnt[s]--;
                    hint_w[s] = w;
                    o.idx = IDX_W'(w * WORD_BITS + b);
                    found = 1'b1;
                end
                else
                begin
                    w++;
                    if (w == words)
                        w = 0;
                end
            end
            if (!found)
            begin
                o.st = STAT_FULL;
                o.idx = '0;
            end
        end
        else if (r.idx >= blk_cnt[s])
            o.st = STAT_RANGE;
        else if (!occ_map[s][r.idx / WORD_BITS][r.idx % WORD_BITS])
            o.st = STAT_NOT_ALLOC;
        else if (r.op == FUNC_FREE)
        begin
            o.tg = tag_mem[s][r.idx];
            o.fl = flag_mem[s][r.idx];
            occ_map[s][r.idx / WORD_BITS][r.idx % WORD_BITS] = 1'b0;
            free_cnt[s]++;
            hint_w[s] = r.idx / WORD_BITS;
            o.allf = (free_cnt[s] == blk_cnt[s]);
        end
        else if (r.op == FUNC_QUERY)
        begin
            o.tg = tag_mem[s][r.idx];
            o.fl = flag_mem[s][r.idx];
        end
        else
            flag_mem[s][r.idx] = r.fl;
        o.nfree = CNT_W'(free_cnt[s]);
        return o;
    endfunction

    // Some allocated block of the planning copy, or -1 if none
    function automatic int find_used(int s);
        int unsigned start;
        int unsigned k;
        int unsigned b;
        start = $urandom_range(blk_cnt[s] - 1);
        for (k = 0; k < blk_cnt[s]; k++)
        begin
            b = (start + k) % blk_cnt[s];
            if (occ_map[s][b / WORD_BITS][b % WORD_BITS])
                return b;
        end
        return -1;
    endfunction

    function automatic req_t make_req(func_t op, int idx, logic [31:0] tg, logic [7:0] fl);
        req_t r;
        r.op = op;
        r.idx = IDX_W'(idx);
        r.tg = tg;
        r.fl = fl;
        return r;
    endfunction

    // Random request; mostly hits live blocks so frees and queries succeed
    function automatic req_t plan_item(bit filling);
        req_t           r;
        int unsigned    roll;
        int             hit;
        r = make_req(FUNC_ALLOC, $urandom_range(SLOTS - 1), $urandom,
                     8'($urandom_range(255)));
        roll = $urandom_range(99);
        if (roll >= (filling ? 65 : 15))
        begin
            roll = $urandom_range(99);
            if (roll < 50)
                r.op = FUNC_FREE;
            else if (roll < 75)
                r.op = FUNC_QUERY;
            else
                r.op = FUNC_SET_FLAGS;
            roll = $urandom_range(99);
            hit = find_used(PLAN);
            if (roll < 80 && hit >= 0)
                r.idx = IDX_W'(hit);
            else if (roll < 90)
                r.idx = IDX_W'($urandom_range(blk_cnt[PLAN] - 1));
        end
        return r;
    endfunction

    function automatic void queue_item(req_t r);
        void'(slab_step(PLAN, r));
        request_backlog.push_back(r);
    endfunction

    task automatic note_mismatch(string msg);
        $display("MISMATCH beat %0d: %s", beats_seen, msg);
        error_count++;
    endtask

    // Wait for every queued request to be answered (called at negedge)
    task automatic drain();
        while (request_backlog.size() != 0 || req_valid || due_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_block_count(logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        block_count <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        slab_configure(PLAN, v);
        slab_configure(TRACK, v);
        cfg_writes++;
    endtask

    // Request driver: predicts each beat as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                due_replies.push_back(slab_step(TRACK, cur_req));
            if (!req_valid || !req_stall)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    cur_req = request_backlog.pop_front();
                    req_valid <= 1'b1;
                    func <= cur_req.op;
                    block_index <= cur_req.idx;
                    tag <= cur_req.tg;
                    new_flags <= cur_req.fl;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                beats_seen++;
                if (due_replies.size() == 0)
                    note_mismatch("result beat with no request outstanding");
                else
                begin
                    want = due_replies.pop_front();
                    op_seen[want.op]++;
                    st_seen[want.st]++;
                    if (want.allf)
                        empty_seen++;
                    if (status !== want.st)
                        note_mismatch($sformatf("status %0d, want %0d", status, want.st));
                    if (granted_index !== want.idx)
                        note_mismatch($sformatf("granted_index %0d, want %0d",
                                                granted_index, want.idx));
                    if (stored_tag !== want.tg)
                        note_mismatch($sformatf("stored_tag %h, want %h", stored_tag, want.tg));
                    if (stored_flags !== want.fl)
                        note_mismatch($sformatf("stored_flags %h, want %h",
                                                stored_flags, want.fl));
                    if (free_blocks !== want.nfree)
                        note_mismatch($sformatf("free_blocks %0d, want %0d",
                                                free_blocks, want.nfree));
                    if (all_free !== want.allf)
                        note_mismatch($sformatf("all_free %b, want %b", all_free, want.allf));
                end
            end
            // one long hold-off on request, otherwise random stalls
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Stimulus sequence
    initial
    begin
        int unsigned    phase_cnt [NUM_PHASES];
        int unsigned    phase_len [NUM_PHASES];
        int unsigned    p;
        int unsigned    half;
        int unsigned    n;
        int unsigned    chunk;
        bit             filling;
        logic [CNT_W-1:0] v;

        phase_cnt = '{70, 2047, 1, 64, 65, 130, 3, 200, 1024, 17, 128, 9};
        phase_len = '{100, 60, 40, 100, 80, 100, 60, 100, 50, 80, 100, 80};
        slab_configure(PLAN, CNT_W'(RESET_BLOCKS));
        slab_configure(TRACK, CNT_W'(RESET_BLOCKS));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full-size slab straight out of reset
        queue_item(make_req(FUNC_QUERY, 0, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 5, 32'h0, 8'h00));
        queue_item(make_req(FUNC_SET_FLAGS, SLOTS - 1, 32'h0, 8'hFF));
        queue_item(make_req(FUNC_ALLOC, 0, 32'h0000_0000, 8'h00));
        queue_item(make_req(FUNC_ALLOC, SLOTS - 1, 32'hFFFF_FFFF, 8'hFF));
        queue_item(make_req(FUNC_ALLOC, 0, $urandom, 8'h00));
        queue_item(make_req(FUNC_SET_FLAGS, 1, 32'h0, 8'hFF));
        queue_item(make_req(FUNC_SET_FLAGS, 0, 32'hFFFF_FFFF, 8'h00));
        queue_item(make_req(FUNC_QUERY, 0, 32'h0, 8'h00));
        queue_item(make_req(FUNC_QUERY, 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_ALLOC, 0, $urandom, 8'h00));
        queue_item(make_req(FUNC_QUERY, 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 0, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 2, 32'h0, 8'h00));
        drain();
        repeat (SETTLE) @(posedge clk);

        // Zero count is taken as a one-block slab
        write_block_count('0);
        @(negedge clk);
        queue_item(make_req(FUNC_ALLOC, 0, 32'hA5A5_0001, 8'h00));
        queue_item(make_req(FUNC_ALLOC, 0, 32'hA5A5_0002, 8'h00));
        queue_item(make_req(FUNC_QUERY, 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, SLOTS - 1, 32'h0, 8'h00));
        queue_item(make_req(FUNC_SET_FLAGS, 0, 32'h0, 8'h5A));
        queue_item(make_req(FUNC_QUERY, 0, 32'h0, 8'h00));
        queue_item(make_req(FUNC_FREE, 0, 32'h0, 8'h00));
        queue_item(make_req(FUNC_SET_FLAGS, 0, 32'h0, 8'hC3));
        queue_item(make_req(FUNC_QUERY, 0, 32'h0, 8'h00));
        drain();

        // Random phases, each at its own block count, split by a full drain
        for (p = 0; p < NUM_PHASES; p++)
        begin
            repeat (SETTLE) @(posedge clk);
            v = (p == NUM_PHASES - 1) ? CNT_W'($urandom_range(2047)) : CNT_W'(phase_cnt[p]);
            write_block_count(v);
            @(negedge clk);
            send_gap_pct = (p == 5) ? 0 : GAP_PCT;
            recv_gap_pct = (p == 5) ? 0 : GAP_PCT;
            filling = 1'b1;
            chunk = $urandom_range(5, 40);
            for (half = 0; half < 2; half++)
            begin
                for (n = 0; n < phase_len[p] / 2; n++)
                begin
                    if (chunk == 0)
                    begin
                        filling = !filling;
                        chunk = $urandom_range(5, 40);
                    end
                    chunk--;
                    queue_item(plan_item(filling));
                end
                if (p == 3 && half == 0)
                    hold_req = 1'b1;
                drain();
            end
        end

        repeat (SETTLE * 2) @(posedge clk);
        $display({"summary: %0d beats checked (alloc %0d, free %0d, query %0d, ",
                  "set-flags %0d), %0d block-count writes"},
                 beats_seen, op_seen[FUNC_ALLOC], op_seen[FUNC_FREE], op_seen[FUNC_QUERY],
                 op_seen[FUNC_SET_FLAGS], cfg_writes);
        $display({"summary: ok %0d, out of range %0d, not allocated %0d, ",
                  "slab full %0d, slab emptied %0d"},
                 st_seen[STAT_OK], st_seen[STAT_RANGE], st_seen[STAT_NOT_ALLOC],
                 st_seen[STAT_FULL], empty_seen);
        if (error_count == 0)
            $display("bitmap_block_allocator_test: clean");
        else
            $display("bitmap_block_allocator_test: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("bitmap_block_allocator_test: errors");
        $finish;
    end

endmodule
